### rtl/ufrt_pkg.sv
package ufrt_pkg;

    localparam int unsigned BUF_DEPTH_DEF = 256;
    localparam int unsigned POS_W         = 9;
    localparam int unsigned QUEUE_DEPTH   = 4;
    localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] FIRST_MATCH_RST  = 8'h01;
    localparam logic [7:0] SECOND_MATCH_RST = 8'd3;
    localparam logic [7:0] RELOAD_RST       = 8'd5;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_READ    = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_FIRST_MATCH  = 2'd0,
        REG_SECOND_MATCH = 2'd1,
        REG_RELOAD       = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_REJECT  = 3'd1,
        EV_COUNT   = 3'd2,
        EV_TIMEOUT = 3'd3,
        EV_IGNORED = 3'd4
    } ev_t;

    // One classified word handed from the front to the back.
    typedef struct packed {
        ev_t              ev;
        logic             frame_ready;
        logic [POS_W-1:0] frame_len;
        logic             wr;
        logic             rd;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_stat_t;

endpackage

### rtl/ufrt_in_if.sv
interface ufrt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;
    logic [7:0] read_index;

    modport source (output valid, output opcode, output rx_byte, output read_index,
                    input ready);
    modport sink (input valid, input opcode, input rx_byte, input read_index,
                  output ready);
endinterface

### rtl/ufrt_out_if.sv
interface ufrt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic       frame_ready;
    logic [8:0] frame_len;
    logic [7:0] read_data;

    modport source (output valid, output event_res, output frame_ready, output frame_len,
                    output read_data, input ready);
    modport sink (input valid, input event_res, input frame_ready, input frame_len,
                  input read_data, output ready);
endinterface

### rtl/ufrt_cfg_if.sv
interface ufrt_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/ufrt_front.sv
module ufrt_front (
    input  logic            clk,
    input  logic            rst_n,
    ufrt_in_if.sink         item,
    ufrt_cfg_if.sink        cfg,
    input  logic            stall,
    output logic            push,
    output ufrt_pkg::entry_t ent
);
    import ufrt_pkg::*;

    localparam logic [POS_W-1:0] POS_ADDR  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_FUNC  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_COUNT = POS_W'(3);

    logic [POS_W-1:0] wp_reg, wp_next, wp_inc;
    logic [7:0]       left_reg, left_next, left_dec;
    logic             done_reg, done_next;
    logic [7:0]       sil_reg, sil_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [7:0]       match0_reg, match1_reg, reload_reg;
    op_t              op;

    assign item.ready = !stall;
    assign cfg.ready  = 1'b1;
    assign push       = item.valid && !stall;
    assign op         = op_t'(item.opcode);

    always_comb
    begin
        wp_inc    = wp_reg + POS_W'(1);
        left_dec  = left_reg - 8'd1;
        wp_next   = wp_reg;
        left_next = left_reg;
        done_next = done_reg;
        sil_next  = sil_reg;
        len_next  = len_reg;
        ent       = '0;
        ent.ev    = EV_NONE;
        ent.pos   = {1'b0, item.read_index};
        ent.data  = item.rx_byte;
        case (op)
            OP_BYTE:
            begin
                if (done_reg)
                begin
                    ent.ev = EV_IGNORED;
                end
                else
                begin
                    sil_next = reload_reg;
                    wp_next  = wp_inc;
                    if (wp_inc == POS_ADDR)
                    begin
                        if (item.rx_byte == match0_reg)
                        begin
                            ent.wr  = 1'b1;
                            ent.pos = '0;
                        end
                        else
                        begin
                            wp_next = '0;
                            ent.ev  = EV_REJECT;
                        end
                    end
                    else if (wp_inc == POS_FUNC)
                    begin
                        if (item.rx_byte == match1_reg)
                        begin
                            ent.wr  = 1'b1;
                            ent.pos = POS_ADDR;
                        end
                        else
                        begin
                            wp_next = '0;
                            ent.ev  = EV_REJECT;
                        end
                    end
                    else if (wp_inc == POS_COUNT)
                    begin
                        left_next = item.rx_byte + 8'd2;
                    end
                    else
                    begin
                        // store at the position just received; a wrapped position is dropped
                        left_next = left_dec;
                        ent.wr    = (wp_inc != '0);
                        ent.pos   = wp_inc - POS_W'(1);
                        if (left_dec == '0)
                        begin
                            len_next  = wp_inc;
                            wp_next   = '0;
                            done_next = 1'b1;
                            ent.ev    = EV_COUNT;
                        end
                    end
                end
            end
            OP_TICK:
            begin
                if (sil_reg != '0)
                begin
                    sil_next = sil_reg - 8'd1;
                end
                else if (wp_reg != '0)
                begin
                    done_next = 1'b1;
                    len_next  = wp_reg;
                    wp_next   = '0;
                    ent.ev    = EV_TIMEOUT;
                end
            end
            OP_READ:
            begin
                ent.rd = 1'b1;
            end
            OP_RELEASE:
            begin
                done_next = 1'b0;
            end
            default:
            begin
                ent.ev = EV_NONE;
            end
        endcase
        ent.frame_ready = done_next;
        ent.frame_len   = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            left_reg <= '0;
            done_reg <= 1'b0;
            sil_reg  <= '0;
            len_reg  <= '0;
        end
        else if (push)
        begin
            wp_reg   <= wp_next;
            left_reg <= left_next;
            done_reg <= done_next;
            sil_reg  <= sil_next;
            len_reg  <= len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match0_reg <= FIRST_MATCH_RST;
            match1_reg <= SECOND_MATCH_RST;
            reload_reg <= RELOAD_RST;
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_FIRST_MATCH:  match0_reg <= cfg.data;
                REG_SECOND_MATCH: match1_reg <= cfg.data;
                REG_RELOAD:       reload_reg <= cfg.data;
                default:          reload_reg <= reload_reg;
            endcase
        end
    end

endmodule

### rtl/ufrt_queue.sv
module ufrt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ufrt_pkg::entry_t  push_ent,
    input  logic              pop,
    output ufrt_pkg::entry_t  head,
    output ufrt_pkg::q_stat_t stat
);
    import ufrt_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.valid = (cnt_reg != '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

### rtl/ufrt_back.sv
module ufrt_back #(
    parameter int unsigned BUF_DEPTH = ufrt_pkg::BUF_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ufrt_pkg::entry_t head,
    input  logic             head_valid,
    output logic             pop,
    output logic             busy,
    ufrt_out_if.source       result
);
    import ufrt_pkg::*;

    localparam int unsigned          AW     = $clog2(BUF_DEPTH);
    localparam logic [AW-1:0]        LAST_A = AW'(BUF_DEPTH - 1);
    localparam logic [POS_W:0]       DEPTH_L = (POS_W+1)'(BUF_DEPTH);

    logic [7:0]    mem [BUF_DEPTH];
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          out_valid_reg;
    ev_t           ev_reg;
    logic          rdy_reg;
    logic [POS_W-1:0] len_reg;
    logic [7:0]    rdata_reg;
    logic          in_range;
    logic [AW-1:0] addr;

    assign busy     = clr_busy_reg;
    assign in_range = ({1'b0, head.pos} < DEPTH_L);
    assign addr     = head.pos[AW-1:0];
    assign pop      = head_valid && !clr_busy_reg && (!out_valid_reg || result.ready);

    assign result.valid       = out_valid_reg;
    assign result.event_res   = ev_reg;
    assign result.frame_ready = rdy_reg;
    assign result.frame_len   = len_reg;
    assign result.read_data   = rdata_reg;

    // after reset, zero the buffer byte by byte from address zero up to the last address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_A)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (pop && head.wr && in_range)
        begin
            mem[addr] <= head.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg    <= head.ev;
            rdy_reg   <= head.frame_ready;
            len_reg   <= head.frame_len;
            rdata_reg <= (head.rd && in_range) ? mem[addr] : 8'd0;
        end
    end

endmodule

### rtl/uart_frame_receiver_with_timeout_unit.sv
// Path: each input word is written into a queue slot, and the back registers its result word.
// Throughput: one input word per cycle while item.ready is high; the front updates all frame
// state for each accepted word, and the four-deep queue absorbs result-side stalls.
// Reset: rst_n is asynchronous; after release the back zeroes all BUF_DEPTH bytes of the
// frame buffer one byte per cycle, holding item.ready low; cfg writes are taken throughout.
module uart_frame_receiver_with_timeout_unit #(
    parameter int unsigned BUF_DEPTH = ufrt_pkg::BUF_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ufrt_in_if.sink    item,
    ufrt_out_if.source result,
    ufrt_cfg_if.sink   cfg
);
    import ufrt_pkg::*;

    entry_t  push_ent;
    entry_t  head;
    q_stat_t q_stat;
    logic    push;
    logic    pop;
    logic    clr_busy;
    logic    stall;

    // hold the input off while the queue is full or the buffer is still being cleared
    assign stall = q_stat.full || clr_busy;

    // front: decode each word, advance frame state, classify the buffer access
    ufrt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cfg   (cfg),
        .stall (stall),
        .push  (push),
        .ent   (push_ent)
    );

    // queue: decouple classification from buffer access and result delivery
    ufrt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // back: perform the buffer write or read in order and register the result word
    ufrt_back #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (q_stat.valid),
        .pop        (pop),
        .busy       (clr_busy),
        .result     (result)
    );

    // no word enters while the buffer clear is running
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !(item.valid && item.ready))
        else $error("input word taken during buffer clear");

    // a completed frame is held with a nonzero length
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.event_res == EV_COUNT || result.event_res == EV_TIMEOUT)
        |-> result.frame_ready && (result.frame_len != '0))
        else $error("frame completion without held frame");

    // an ignored byte only happens while a frame is held
    a_ignore_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.event_res == EV_IGNORED) |-> result.frame_ready)
        else $error("byte ignored with no frame held");

endmodule
